@@ src/pmx_pkg.sv @@
package pmx_pkg;

  localparam int CITY_W     = 6;
  localparam int CITY_SPACE = 64;
  localparam int LEN_W      = 7;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_EMIT_RD,
    ST_EMIT_START,
    ST_WALK
  } state_e;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic              load_we;
    logic              run_start;
    logic              build_rd;
    logic              chain_start;
    logic              capture;
    logic [CITY_W-1:0] addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              n_zero;
    logic              seg_empty;
    logic [CITY_W-1:0] norm_left;
    logic              build_last;
    logic              emit_last;
    logic              walk_done;
    logic              out_free;
  } dp_status_t;

endpackage

@@ src/pmx_ram.sv @@
module pmx_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pmx_chain.sv @@
module pmx_chain (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      wr_en_i,
  input  logic [pmx_pkg::CITY_W-1:0] wr_key_i,
  input  logic [pmx_pkg::CITY_W-1:0] wr_val_i,
  input  logic                      start_i,
  input  logic                      bypass_i,
  input  logic [pmx_pkg::CITY_W-1:0] start_val_i,
  input  logic [pmx_pkg::LEN_W-1:0]  limit_i,
  output logic                      busy_o,
  output logic [pmx_pkg::CITY_W-1:0] val_o,
  output logic                      fault_o
);
  import pmx_pkg::*;

  logic [CITY_SPACE-1:0] vld_q, vld_d;
  logic [CITY_W-1:0]     v_q, v_d;
  logic [LEN_W-1:0]      steps_q, steps_d;
  logic                  busy_q, busy_d;
  logic                  take_q, take_d;
  logic                  fault_q, fault_d;
  logic [CITY_W-1:0]     map_rdata;
  logic [CITY_W-1:0]     cur;
  logic [LEN_W-1:0]      step_cnt;
  logic                  active;

  pmx_ram #(
    .WIDTH(CITY_W),
    .DEPTH(CITY_SPACE)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_key_i),
    .wdata_i(wr_val_i),
    .raddr_i(cur),
    .rdata_o(map_rdata)
  );

  always_comb begin
    vld_d = vld_q;
    if (clr_i) begin
      vld_d = '0;
    end else if (wr_en_i) begin
      vld_d[wr_key_i] = 1'b1;
    end
  end

  always_comb begin
    if (start_i) begin
      cur = start_val_i;
    end else if (take_q) begin
      cur = map_rdata;
    end else begin
      cur = v_q;
    end
    step_cnt = start_i ? '0 : steps_q;
    active   = (start_i && !bypass_i) || busy_q;

    v_d     = v_q;
    steps_d = steps_q;
    busy_d  = busy_q;
    take_d  = 1'b0;
    fault_d = fault_q;
    if (start_i && bypass_i) begin
      v_d     = start_val_i;
      busy_d  = 1'b0;
      fault_d = 1'b0;
    end else if (active) begin
      v_d = cur;
      if ((step_cnt < limit_i) && vld_q[cur]) begin
        steps_d = step_cnt + 7'd1;
        busy_d  = 1'b1;
        take_d  = 1'b1;
      end else begin
        busy_d  = 1'b0;
        fault_d = vld_q[cur];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      busy_q <= 1'b0;
      take_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      busy_q <= busy_d;
      take_q <= take_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    steps_q <= steps_d;
    fault_q <= fault_d;
  end

  assign busy_o  = busy_q;
  assign val_o   = v_q;
  assign fault_o = fault_q;

endmodule

@@ src/pmx_datapath.sv @@
module pmx_datapath #(
  parameter int MAX_CITIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pmx_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic                          cfg_valid_i,
  input  logic [pmx_pkg::LEN_W-1:0]      cfg_data_i,
  input  pmx_pkg::ctrl_cmd_t            cmd_i,
  output pmx_pkg::dp_status_t           status_o,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [pmx_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic                          m_tuser_o,
  output logic                          m_tlast_o
);
  import pmx_pkg::*;

  localparam int AW = $clog2(MAX_CITIES);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CITIES);

  logic [CITY_W-1:0] position, father_city, mother_city, cut_a, cut_b;
  logic [LEN_W-1:0]  tour_len_q;
  logic [LEN_W-1:0]  n_len, nm1, l, r, t;
  logic [CITY_W-1:0] left_q, right_q;
  logic [LEN_W-1:0]  n_q;
  logic              map_we_q;
  logic              store_we;
  logic [CITY_W-1:0] f_rdata, m_rdata;
  logic              in_seg;
  logic              emit_last;
  logic              busy_one, busy_two;
  logic              fault_one, fault_two;
  logic [CITY_W-1:0] val_one, val_two;
  logic              out_valid_q;
  logic [CITY_W-1:0] out_pos_q, out_c1_q, out_c2_q;
  logic              out_fault_q, out_last_q;

  assign position    = s_tdata_i[5:0];
  assign father_city = s_tdata_i[11:6];
  assign mother_city = s_tdata_i[17:12];
  assign cut_a       = s_tdata_i[23:18];
  assign cut_b       = s_tdata_i[29:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tour_len_q <= LEN_RESET;
    end else if (cfg_valid_i) begin
      tour_len_q <= cfg_data_i;
    end
  end

  // cut point normalisation
  always_comb begin
    n_len = (tour_len_q > MAX_LEN) ? MAX_LEN : tour_len_q;
    nm1   = n_len - 7'd1;
    l     = {1'b0, cut_a};
    r     = {1'b0, cut_b};
    if (l > nm1) begin
      l = nm1;
    end
    if (r > nm1) begin
      r = nm1;
    end
    if (l == r) begin
      if ((l + 7'd1) < n_len) begin
        r = l + 7'd1;
      end else begin
        l = l - 7'd1;
      end
    end
    if (l > r) begin
      t = l;
      l = r;
      r = t;
    end else begin
      t = r;
    end
    if (n_len == 7'd1) begin
      l = '0;
      r = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) begin
      left_q  <= l[CITY_W-1:0];
      right_q <= r[CITY_W-1:0];
      n_q     <= n_len;
    end
  end

  assign store_we = cmd_i.load_we && ({1'b0, position} < MAX_LEN);

  pmx_ram #(
    .WIDTH(CITY_W),
    .DEPTH(MAX_CITIES)
  ) u_father (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(position[AW-1:0]),
    .wdata_i(father_city),
    .raddr_i(cmd_i.addr[AW-1:0]),
    .rdata_o(f_rdata)
  );

  pmx_ram #(
    .WIDTH(CITY_W),
    .DEPTH(MAX_CITIES)
  ) u_mother (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(position[AW-1:0]),
    .wdata_i(mother_city),
    .raddr_i(cmd_i.addr[AW-1:0]),
    .rdata_o(m_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_we_q <= 1'b0;
    end else begin
      map_we_q <= cmd_i.build_rd;
    end
  end

  assign in_seg    = (cmd_i.addr >= left_q) && (cmd_i.addr < right_q);
  assign emit_last = (({1'b0, cmd_i.addr} + 7'd1) == n_q);

  // child one: mother -> father map; child two: father -> mother map
  pmx_chain u_chain_one (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cmd_i.run_start),
    .wr_en_i    (map_we_q),
    .wr_key_i   (m_rdata),
    .wr_val_i   (f_rdata),
    .start_i    (cmd_i.chain_start),
    .bypass_i   (in_seg),
    .start_val_i(in_seg ? m_rdata : f_rdata),
    .limit_i    (n_q),
    .busy_o     (busy_one),
    .val_o      (val_one),
    .fault_o    (fault_one)
  );

  pmx_chain u_chain_two (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cmd_i.run_start),
    .wr_en_i    (map_we_q),
    .wr_key_i   (f_rdata),
    .wr_val_i   (m_rdata),
    .start_i    (cmd_i.chain_start),
    .bypass_i   (in_seg),
    .start_val_i(in_seg ? f_rdata : m_rdata),
    .limit_i    (n_q),
    .busy_o     (busy_two),
    .val_o      (val_two),
    .fault_o    (fault_two)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.capture) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      out_pos_q   <= cmd_i.addr;
      out_c1_q    <= val_one;
      out_c2_q    <= val_two;
      out_fault_q <= fault_one | fault_two;
      out_last_q  <= emit_last;
    end
  end

  assign status_o.n_zero     = (n_len == '0);
  assign status_o.seg_empty  = (l == r);
  assign status_o.norm_left  = l[CITY_W-1:0];
  assign status_o.build_last = (({1'b0, cmd_i.addr} + 7'd1) == {1'b0, right_q});
  assign status_o.emit_last  = emit_last;
  assign status_o.walk_done  = !busy_one && !busy_two;
  assign status_o.out_free   = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'd0, out_c2_q, out_c1_q, out_pos_q};
  assign m_tuser_o  = out_fault_q;
  assign m_tlast_o  = out_last_q;

endmodule

@@ src/pmx_ctrl.sv @@
module pmx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_cmd_i,
  output logic                s_tready_o,
  input  pmx_pkg::dp_status_t status_i,
  output pmx_pkg::ctrl_cmd_t  cmd_o
);
  import pmx_pkg::*;

  state_e            state_q, state_d;
  logic [CITY_W-1:0] idx_q, idx_d;
  logic              accept;
  logic              run_go;

  assign accept = (state_q == ST_IDLE) && s_tvalid_i;
  assign run_go = accept && (s_cmd_i == CMD_RUN) && !status_i.n_zero;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (run_go) begin
          if (status_i.seg_empty) begin
            state_d = ST_EMIT_RD;
            idx_d   = '0;
          end else begin
            state_d = ST_BUILD;
            idx_d   = status_i.norm_left;
          end
        end
      end
      ST_BUILD: begin
        if (status_i.build_last) begin
          state_d = ST_EMIT_RD;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_START;
      end
      ST_EMIT_START: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (status_i.walk_done && status_i.out_free) begin
          if (status_i.emit_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
            idx_d   = idx_q + 6'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready_o        = (state_q == ST_IDLE);
    cmd_o.load_we     = accept && (s_cmd_i == CMD_LOAD);
    cmd_o.run_start   = run_go;
    cmd_o.build_rd    = (state_q == ST_BUILD);
    cmd_o.chain_start = (state_q == ST_EMIT_START);
    cmd_o.capture     = (state_q == ST_WALK) && status_i.walk_done && status_i.out_free;
    cmd_o.addr        = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ src/pmx_crossover_core.sv @@
// Partially mapped crossover of two tours. A load transfer (tuser 0) writes one father and
// one mother city at a position. A run transfer (tuser 1) normalises the cut points in its
// accept cycle, then steps through the segment positions building the two value maps, and
// then for each tour position reads both parents, starts the two map chains and walks them
// (the longer of the two chains, at most tour_length steps capped at MAX_CITIES), one step
// at a time through the single registered read port of each map memory. One result transfer
// is emitted per position; a stalled output holds the walk of the next position back. Input
// is refused while a run is in progress.
module pmx_crossover_core #(
  parameter int MAX_CITIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // position, father_city, mother_city, cut_a, cut_b, zero fill
  input  logic [31:0] s_axis_tdata_i,
  // cmd
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_position, child_one_city, child_two_city, zero fill
  output logic [23:0] m_axis_tdata_o,
  // chain_fault
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);
  import pmx_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  pmx_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_cmd_i   (s_axis_tuser_i),
    .s_tready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pmx_datapath #(
    .MAX_CITIES(MAX_CITIES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ bench/pmx_crossover_core_tb.sv @@
`timescale 1ns / 100ps

module pmx_crossover_core_tb;
  import pmx_pkg::*;

  localparam int MAX_CITIES     = 64;
  localparam int ITEM_TARGET    = 230;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct packed {
    logic [CITY_W-1:0] pos;
    logic [CITY_W-1:0] child_one;
    logic [CITY_W-1:0] child_two;
    logic              fault;
    logic              is_last;
  } child_gene_t;

  class crossover_scoreboard;
    logic [CITY_W-1:0] father_tour [CITY_SPACE];
    logic [CITY_W-1:0] mother_tour [CITY_SPACE];
    logic [CITY_W-1:0] one_val [CITY_SPACE];
    logic [CITY_W-1:0] two_val [CITY_SPACE];
    bit                one_vld [CITY_SPACE];
    bit                two_vld [CITY_SPACE];
    int unsigned       tour_len;
    child_gene_t       expected_genes [$];
    int                errors;

    function new();
      tour_len = 32'(LEN_RESET);
      errors   = 0;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function logic [CITY_W-1:0] follow_map(bit second, logic [CITY_W-1:0] start,
                                           int unsigned len, output bit cut_off);
      logic [CITY_W-1:0] v;
      int unsigned       steps;
      v     = start;
      steps = 0;
      while (steps < len && (second ? two_vld[v] : one_vld[v])) begin
        v = second ? two_val[v] : one_val[v];
        steps++;
      end
      cut_off = second ? two_vld[v] : one_vld[v];
      return v;
    endfunction

    function void breed_children(logic [CITY_W-1:0] cut_a, logic [CITY_W-1:0] cut_b);
      int unsigned       n, lo, hi, tmp, i;
      logic [CITY_W-1:0] f, m;
      bit                f1, f2;
      child_gene_t       g;
      n = (tour_len > MAX_CITIES) ? MAX_CITIES : tour_len;
      if (n == 0) return;
      for (i = 0; i < CITY_SPACE; i++) begin
        one_vld[i] = 0;
        two_vld[i] = 0;
      end
      if (n < 2) begin
        g = '{pos: '0, child_one: father_tour[0], child_two: mother_tour[0],
              fault: 1'b0, is_last: 1'b1};
        expected_genes = {expected_genes, g};
        return;
      end
      lo = 32'(cut_a);
      hi = 32'(cut_b);
      if (lo > n - 1) lo = n - 1;
      if (hi > n - 1) hi = n - 1;
      if (lo == hi) begin
        if (lo + 1 < n) hi = lo + 1;
        else lo = lo - 1;
      end
      if (lo > hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      for (i = lo; i < hi; i++) begin
        f = father_tour[i];
        m = mother_tour[i];
        one_val[m] = f;
        one_vld[m] = 1;
        two_val[f] = m;
        two_vld[f] = 1;
      end
      for (i = 0; i < n; i++) begin
        g.pos     = i[CITY_W-1:0];
        g.is_last = (i + 1 == n);
        if (i >= lo && i < hi) begin
          g.child_one = mother_tour[i];
          g.child_two = father_tour[i];
          g.fault     = 1'b0;
        end else begin
          g.child_one = follow_map(1'b0, father_tour[i], n, f1);
          g.child_two = follow_map(1'b1, mother_tour[i], n, f2);
          g.fault     = f1 | f2;
        end
        expected_genes = {expected_genes, g};
      end
    endfunction

    function void accept_item(logic cmd, logic [31:0] d);
      if (cmd == CMD_LOAD) begin
        father_tour[d[5:0]] = d[11:6];
        mother_tour[d[5:0]] = d[17:12];
      end else begin
        breed_children(d[23:18], d[29:24]);
      end
    endfunction

    task check_gene(logic [23:0] d, logic fault, logic is_last);
      child_gene_t g;
      if (expected_genes.size() == 0) begin
        report($sformatf("unexpected result pos %0d", d[5:0]));
        return;
      end
      g = expected_genes.pop_front();
      if (d[5:0] !== g.pos)
        report($sformatf("position got %0d want %0d", d[5:0], g.pos));
      if (d[11:6] !== g.child_one)
        report($sformatf("pos %0d child one got %0d want %0d", g.pos, d[11:6], g.child_one));
      if (d[17:12] !== g.child_two)
        report($sformatf("pos %0d child two got %0d want %0d", g.pos, d[17:12], g.child_two));
      if (fault !== g.fault)
        report($sformatf("pos %0d chain fault got %0b want %0b", g.pos, fault, g.fault));
      if (is_last !== g.is_last)
        report($sformatf("pos %0d last got %0b want %0b", g.pos, is_last, g.is_last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [6:0]  cfg_data = '0;
  logic        calm = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_ready_o;

  crossover_scoreboard sb;
  int items_sent = 0;
  int rx_wait = 0;
  int quiet_cycles = 0;

  pmx_crossover_core #(
    .MAX_CITIES(MAX_CITIES)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // alternating stretches with and without idling
  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk_i);
      calm <= ~calm;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        sb.check_gene(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        rx_wait = pick_gap();
        if (rx_wait > 0) begin
          m_ready <= 1'b0;
          rx_wait--;
        end
      end else if (rx_wait > 0) begin
        rx_wait--;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic cmd, logic [5:0] pos, logic [5:0] fcity,
                           logic [5:0] mcity, logic [5:0] ca, logic [5:0] cb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {2'b00, cb, ca, mcity, fcity, pos};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.accept_item(s_user, s_data);
    items_sent++;
  endtask

  task automatic load_gene(logic [5:0] pos, logic [5:0] fcity, logic [5:0] mcity);
    send_item(CMD_LOAD, pos, fcity, mcity, 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)));
  endtask

  task automatic run_cross(logic [5:0] ca, logic [5:0] cb);
    send_item(CMD_RUN, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)), ca, cb);
  endtask

  task automatic idle_input();
    s_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.expected_genes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_length(logic [6:0] len);
    idle_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sb.tour_len = 32'(len);
  endtask

  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
          (cfg_valid && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int          r, len, n, i, k, runs;
    logic [5:0]  tmp, fc, mc;
    logic [5:0]  pool [64];
    int          order [64];
    int          swap_i;
    bit          flaw;

    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single city tour passes straight through
    write_length(7'd1);
    load_gene(6'd0, 6'd63, 6'd0);
    run_cross(6'd0, 6'd0);
    // empty tour gives nothing
    write_length(7'd0);
    run_cross(6'd5, 6'd9);
    // four cities: equal cuts, cut at the end, reversed cuts, saturation
    write_length(7'd4);
    load_gene(6'd0, 6'd3, 6'd63);
    load_gene(6'd1, 6'd63, 6'd0);
    load_gene(6'd2, 6'd10, 6'd3);
    load_gene(6'd3, 6'd0, 6'd10);
    run_cross(6'd1, 6'd1);
    run_cross(6'd3, 6'd3);
    run_cross(6'd3, 6'd0);
    run_cross(6'd63, 6'd63);
    run_cross(6'd0, 6'd63);
    // looping map chain from duplicated cities
    load_gene(6'd0, 6'd5, 6'd6);
    load_gene(6'd1, 6'd6, 6'd5);
    load_gene(6'd2, 6'd5, 6'd6);
    run_cross(6'd0, 6'd2);
    load_gene(6'd63, 6'd63, 6'd63);

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 5) len = $urandom_range(0, 1);
      else if (r < 70) len = $urandom_range(2, 8);
      else if (r < 85) len = $urandom_range(9, 20);
      else if (r < 93) len = 64;
      else if (r < 97) len = $urandom_range(65, 126);
      else len = 127;
      write_length(len[6:0]);
      n = (len > MAX_CITIES) ? MAX_CITIES : len;

      for (i = 0; i < 64; i++) begin
        pool[i]  = i[5:0];
        order[i] = i;
      end
      for (i = 63; i > 0; i--) begin
        k = $urandom_range(0, i);
        tmp = pool[i];
        pool[i] = pool[k];
        pool[k] = tmp;
      end
      for (i = n - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        swap_i = order[i];
        order[i] = order[k];
        order[k] = swap_i;
      end
      flaw = ($urandom_range(0, 4) == 0);
      for (i = 0; i < n; i++) begin
        fc = pool[i];
        mc = pool[order[i]];
        if (flaw && $urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 0) fc = 6'($urandom_range(0, 63));
          else mc = 6'($urandom_range(0, 63));
        end
        load_gene(i[5:0], fc, mc);
      end

      runs = $urandom_range(1, 3);
      repeat (runs) begin
        if ($urandom_range(0, 3) == 0)
          load_gene(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63)));
        if ($urandom_range(0, 5) == 0) begin
          idle_input();
          wait_drained();
        end
        if (n > 0 && $urandom_range(0, 1) == 0)
          run_cross(6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
        else
          run_cross(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end
    end

    idle_input();
    wait_drained();
    repeat (3 * SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_genes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pmx_pkg.sv
src/pmx_ram.sv
src/pmx_chain.sv
src/pmx_datapath.sv
src/pmx_ctrl.sv
src/pmx_crossover_core.sv
bench/pmx_crossover_core_tb.sv
